>>> hw/rtl/tcce_pkg.sv
// Shared types and constants for the text console character engine.
// Used by tcce_engine and text_console_char_engine_core; no dependencies.
`default_nettype none

package tcce_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int TAB_LIMIT = COLUMNS - 5;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int TAB_W  = $clog2(TAB_WIDTH + 1);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    CMD_PUTC    = 3'd0,
    CMD_PUTC_AT = 3'd1,
    CMD_SET_POS = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SCROLL_OFF = 2'd1,
    ST_RANGE      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BG     = 2'd0,
    REG_FG     = 2'd1,
    REG_SCROLL = 2'd2,
    REG_CURSOR = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_PRINT,
    S_BS_WR,
    S_BS_BLANK,
    S_SCR_RD,
    S_SCR_WR,
    S_SCR_BLANK,
    S_CLEAR,
    S_RD_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [3:0] cell_fg;
    logic [3:0] cell_bg;
    logic [6:0] row_in;
    logic [7:0] col_in;
    logic [7:0] char_code;
    logic [2:0] cmd;
  } req_t;

  typedef struct packed {
    logic       scroll_en;
    logic [3:0] fg;
    logic [2:0] bg;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cell_data;
    logic [10:0] cursor_offset;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcce_engine.sv
// Command sequencer, cursor and 1R1W screen store of the console engine.
// Depends on tcce_pkg.
`default_nettype none

module tcce_engine
  import tcce_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [COL_W-1:0]  pos_col_q, pos_col_d;
  logic [ROW_W-1:0]  pos_row_q, pos_row_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [TAB_W-1:0]  tab_cnt_q, tab_cnt_d;
  logic [15:0]       cell_q, cell_d;
  status_e           status_q, status_d;

  logic [15:0]       screen_q [CELLS];
  logic [15:0]       rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [15:0]       mem_wd;

  logic [ADDR_W-1:0] cur_idx, in_idx;
  logic [15:0]       blank;
  logic [7:0]        print_ch;
  logic              col_ok, row_ok, in_bounds;
  logic              at_last_row, at_last_col, tab_feeds, ld_scroll;
  logic              do_ld;
  logic [COL_W-1:0]  in_col, clamp_col;
  logic [ROW_W-1:0]  in_row, clamp_row;

  assign cur_idx = ADDR_W'(ADDR_W'(pos_row_q) * ADDR_W'(COLUMNS)) + ADDR_W'(pos_col_q);
  assign blank   = {1'b0, cfg_i.bg, cfg_i.fg, 8'h00};
  assign print_ch = (req_q.char_code == CH_TAB) ? CH_SPACE : req_q.char_code;

  assign col_ok = !req_q.col_in[7] && ({1'b0, req_q.col_in[6:0]} < 8'(COLUMNS));
  assign row_ok = !req_q.row_in[6] && ({1'b0, req_q.row_in[5:0]} < 7'(ROWS));
  assign in_bounds = col_ok && row_ok;
  assign in_col = COL_W'(req_q.col_in[6:0]);
  assign in_row = ROW_W'(req_q.row_in[5:0]);
  assign in_idx = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(COLUMNS)) + ADDR_W'(in_col);

  always_comb begin
    if (req_q.col_in[7]) begin
      clamp_col = '0;
    end else if ({1'b0, req_q.col_in[6:0]} > 8'(COLUMNS - 1)) begin
      clamp_col = COL_W'(COLUMNS - 1);
    end else begin
      clamp_col = in_col;
    end
    if (req_q.row_in[6]) begin
      clamp_row = '0;
    end else if ({1'b0, req_q.row_in[5:0]} > 7'(ROWS - 1)) begin
      clamp_row = ROW_W'(ROWS - 1);
    end else begin
      clamp_row = in_row;
    end
  end

  assign at_last_row = (pos_row_q == ROW_W'(ROWS - 1));
  assign at_last_col = (pos_col_q == COL_W'(COLUMNS - 1));
  assign tab_feeds   = ({1'b0, pos_col_q} >= (COL_W + 1)'(TAB_LIMIT));
  assign ld_scroll   = at_last_row && cfg_i.scroll_en;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (ptr_q == ADDR_W'(CELLS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (cmd_e'(req_q.cmd))
          CMD_PUTC: begin
            if ((req_q.char_code == CH_TAB && tab_feeds) || req_q.char_code == CH_LF) begin
              state_d = ld_scroll ? S_SCR_RD : S_DONE;
            end else if (req_q.char_code == CH_TAB) begin
              state_d = S_PRINT;
            end else if (req_q.char_code == CH_BS) begin
              state_d = (pos_row_q == '0 && pos_col_q == '0) ? S_DONE : S_BS_WR;
            end else if (req_q.char_code == CH_CR) begin
              state_d = S_DONE;
            end else begin
              state_d = S_PRINT;
            end
          end
          CMD_CLEAR: state_d = S_CLEAR;
          CMD_READ:  state_d = in_bounds ? S_RD_WAIT : S_DONE;
          default:   state_d = S_DONE;
        endcase
      end
      S_PRINT: begin
        if (at_last_col && ld_scroll) begin
          state_d = S_SCR_RD;
        end else if (tab_cnt_q > TAB_W'(1)) begin
          state_d = S_PRINT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_BS_WR:    state_d = S_BS_BLANK;
      S_BS_BLANK: state_d = S_DONE;
      S_SCR_RD:   state_d = S_SCR_WR;
      S_SCR_WR: begin
        state_d = (ptr_q == ADDR_W'(CELLS - COLUMNS - 1)) ? S_SCR_BLANK : S_SCR_RD;
      end
      S_SCR_BLANK: begin
        if (ptr_q == ADDR_W'(CELLS - 1)) begin
          state_d = (tab_cnt_q != '0) ? S_PRINT : S_DONE;
        end
      end
      S_CLEAR: begin
        if (ptr_q == ADDR_W'(CELLS - 1)) state_d = S_DONE;
      end
      S_RD_WAIT: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and store controls
  always_comb begin
    req_d     = req_q;
    pos_col_d = pos_col_q;
    pos_row_d = pos_row_q;
    ptr_d     = ptr_q;
    tab_cnt_d = tab_cnt_q;
    cell_d    = cell_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_wa    = cur_idx;
    mem_wd    = blank;
    mem_ra    = cur_idx;
    do_ld     = 1'b0;
    case (state_q)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        mem_wd = '0;
        ptr_d  = ADDR_W'(ptr_q + ADDR_W'(1));
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d    = req_i;
          status_d = ST_OK;
          cell_d   = '0;
        end
      end
      S_EXEC: begin
        case (cmd_e'(req_q.cmd))
          CMD_PUTC: begin
            if ((req_q.char_code == CH_TAB && tab_feeds) || req_q.char_code == CH_LF) begin
              tab_cnt_d = '0;
              do_ld     = 1'b1;
            end else if (req_q.char_code == CH_TAB) begin
              tab_cnt_d = TAB_W'(TAB_WIDTH);
            end else if (req_q.char_code == CH_BS) begin
              // current cell is read here, lands in rdata_q for the copy
              mem_ra = cur_idx;
            end else if (req_q.char_code == CH_CR) begin
              pos_col_d = '0;
            end else begin
              tab_cnt_d = TAB_W'(1);
            end
          end
          CMD_PUTC_AT: begin
            if (in_bounds) begin
              mem_we = 1'b1;
              mem_wa = in_idx;
              mem_wd = {req_q.cell_bg, req_q.cell_fg, req_q.char_code};
            end else begin
              status_d = ST_RANGE;
            end
          end
          CMD_SET_POS: begin
            if (!in_bounds) status_d = ST_RANGE;
            pos_col_d = clamp_col;
            pos_row_d = clamp_row;
          end
          CMD_CLEAR: ptr_d = '0;
          CMD_READ: begin
            mem_ra = in_idx;
            if (!in_bounds) status_d = ST_RANGE;
          end
          default: ;
        endcase
      end
      S_PRINT: begin
        mem_we    = 1'b1;
        mem_wd    = blank | {8'h00, print_ch};
        tab_cnt_d = TAB_W'(tab_cnt_q - TAB_W'(1));
        if (at_last_col) begin
          do_ld = 1'b1;
        end else begin
          pos_col_d = COL_W'(pos_col_q + COL_W'(1));
        end
      end
      S_BS_WR: begin
        mem_we = 1'b1;
        mem_wa = ADDR_W'(cur_idx - ADDR_W'(1));
        mem_wd = rdata_q;
      end
      S_BS_BLANK: begin
        mem_we = 1'b1;
        if (pos_col_q == '0) begin
          pos_row_d = ROW_W'(pos_row_q - ROW_W'(1));
          pos_col_d = COL_W'(COLUMNS - 1);
        end else begin
          pos_col_d = COL_W'(pos_col_q - COL_W'(1));
        end
      end
      S_SCR_RD: begin
        mem_ra = ADDR_W'(ptr_q + ADDR_W'(COLUMNS));
      end
      S_SCR_WR: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        mem_wd = rdata_q;
        ptr_d  = ADDR_W'(ptr_q + ADDR_W'(1));
      end
      S_SCR_BLANK, S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        ptr_d  = ADDR_W'(ptr_q + ADDR_W'(1));
        if (state_q == S_CLEAR) begin
          pos_col_d = '0;
          pos_row_d = '0;
        end
      end
      S_RD_WAIT: cell_d = rdata_q;
      default: ;
    endcase

    // Line feed: home the column, then step down, scroll or flag
    if (do_ld) begin
      pos_col_d = '0;
      ptr_d     = '0;
      if (!at_last_row) begin
        pos_row_d = ROW_W'(pos_row_q + ROW_W'(1));
      end else if (!cfg_i.scroll_en) begin
        status_d = ST_SCROLL_OFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      pos_col_q <= '0;
      pos_row_q <= '0;
      ptr_q     <= '0;
      tab_cnt_q <= '0;
      status_q  <= ST_OK;
    end else begin
      state_q   <= state_d;
      pos_col_q <= pos_col_d;
      pos_row_q <= pos_row_d;
      ptr_q     <= ptr_d;
      tab_cnt_q <= tab_cnt_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= screen_q[mem_ra];
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.cursor_col    = 7'(pos_col_q);
    res_o.cursor_row    = 5'(pos_row_q);
    res_o.cursor_offset = 11'(cur_idx);
    res_o.cell_data     = cell_q;
    res_o.status        = status_q;
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_col_q} < (COL_W + 1)'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_row_q} < (ROW_W + 1)'(ROWS))
    else $error("cursor row out of range");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == S_EXEC)
    else $error("accepted request not executed");

  a_scroll_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCR_WR |-> {1'b0, ptr_q} < (ADDR_W + 1)'(CELLS - COLUMNS))
    else $error("scroll copy past the last source row");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (status_q == ST_OK || status_q == ST_SCROLL_OFF ||
                     status_q == ST_RANGE))
    else $error("bad status code");

endmodule

`default_nettype wire

>>> hw/rtl/text_console_char_engine_core.sv
// Top level of the text console character engine: APB registers, stream
// ports and the result register. Depends on tcce_pkg and tcce_engine.
//
//  port group  | dir | contents
//  s_axis_*    | in  | one command request per handshake
//  m_axis_*    | out | one result per request
//  APB         | in  | color, scroll and cursor registers
//
// read does one registered read of the screen store. A scroll walks the store:
// each cell below the top row is read in S_SCR_RD and written one row up in
// S_SCR_WR, then the last row is blanked. clear writes all CELLS cells. After
// reset a pass over all CELLS cells zeroes the store, with s_axis_tready low.
// A stalled result is held in the output register.
`default_nettype none

module text_console_char_engine_core
  import tcce_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // cmd[2:0] char_code[10:3] col_in[18:11] row_in[25:19] cell_bg[29:26]
  // cell_fg[33:30], zero pad [39:34]
  input  wire logic [39:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // cursor_col[6:0] cursor_row[11:7] cursor_offset[22:12] cursor_shown[23]
  // cell_data[39:24] status[41:40], zero pad [47:42]
  output logic [47:0]      m_axis_tdata_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [2:0] bg_q;
  logic [3:0] fg_q;
  logic       scroll_en_q;
  logic       cursor_en_q;
  logic       reg_we;

  cfg_t  cfg;
  req_t  req;
  res_t  res;
  logic  res_valid, res_ready;

  logic        m_valid_q;
  logic [47:0] m_data_q;

  assign pready = 1'b1;
  assign reg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q        <= 3'd0;
      fg_q        <= 4'd7;
      scroll_en_q <= 1'b0;
      cursor_en_q <= 1'b0;
    end else if (reg_we) begin
      case (reg_e'(paddr[3:2]))
        REG_BG:     bg_q        <= pwdata[2:0];
        REG_FG:     fg_q        <= pwdata[3:0];
        REG_SCROLL: scroll_en_q <= pwdata[0];
        REG_CURSOR: cursor_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_BG:     prdata = {29'd0, bg_q};
      REG_FG:     prdata = {28'd0, fg_q};
      REG_SCROLL: prdata = {31'd0, scroll_en_q};
      REG_CURSOR: prdata = {31'd0, cursor_en_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg.bg        = bg_q;
  assign cfg.fg        = fg_q;
  assign cfg.scroll_en = scroll_en_q;

  assign req = req_t'(s_axis_tdata_i[33:0]);

  tcce_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Take a new result when the output register is empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= {6'd0, res.status, res.cell_data, cursor_en_q, res.cursor_offset,
                   res.cursor_row, res.cursor_col};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready_i |=> m_valid_q)
    else $error("pending result dropped");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("engine left done while output full");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !res_valid)
    else $error("ready while a result is pending in the engine");

endmodule

`default_nettype wire
